@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL; chr_latch_bank_mapper_top includes them.
// Each macro takes a label, an antecedent and a consequent, clocked on clk_i
// and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed in same cycle check");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in next cycle check");

`endif

@@ rtl/clbm_pkg.sv @@
// ----------------------------------------------------------------------------
// clbm_pkg
// Types and constants shared by the latch bank mapper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clbm_pkg;

  localparam logic [1:0] CMD_CPU_RD = 2'd0;
  localparam logic [1:0] CMD_CPU_WR = 2'd1;
  localparam logic [1:0] CMD_PPU_RD = 2'd2;
  localparam logic [1:0] CMD_PPU_WR = 2'd3;

  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_PRG_ROM = 3'd1;
  localparam logic [2:0] TGT_PRG_RAM = 3'd2;
  localparam logic [2:0] TGT_CHR_ROM = 3'd3;
  localparam logic [2:0] TGT_CHR_RAM = 3'd4;

  localparam logic [1:0] REG_PRG_COUNT = 2'd0;
  localparam logic [1:0] REG_PRG_MASK  = 2'd1;
  localparam logic [1:0] REG_CHR_MASK  = 2'd2;
  localparam logic [1:0] REG_CHR_RAM   = 2'd3;

  localparam logic [3:0] WR_PRG_BANK = 4'hA;
  localparam logic [3:0] WR_PAGE_LFD = 4'hB;
  localparam logic [3:0] WR_PAGE_LFE = 4'hC;
  localparam logic [3:0] WR_PAGE_RFD = 4'hD;
  localparam logic [3:0] WR_PAGE_RFE = 4'hE;

  localparam logic [13:0] TRIG_FD_LO = 14'h0FD8;
  localparam logic [13:0] TRIG_FD_HI = 14'h1FD8;
  localparam logic [13:0] TRIG_FE_LO = 14'h0FE8;
  localparam logic [13:0] TRIG_FE_HI = 14'h1FE8;

  localparam logic [15:0] ADDR_PRG_RAM = 16'h6000;
  localparam logic [15:0] ADDR_PRG_SW  = 16'h8000;
  localparam logic [15:0] ADDR_PRG_FIX = 16'hA000;

  localparam int unsigned BANK_W  = 4;
  localparam int unsigned COUNT_W = 6;

  typedef struct packed {
    logic                 start;
    logic [BANK_W-1:0]    dividend;
    logic [COUNT_W-1:0]   divisor;
  } mod_ctrl_t;

  typedef struct packed {
    logic                 busy;
    logic                 valid;
    logic [BANK_W-1:0]    remainder;
  } mod_sts_t;

endpackage

`default_nettype wire

@@ rtl/clbm_mod_unit.sv @@
// ----------------------------------------------------------------------------
// clbm_mod_unit
// Restoring remainder unit: one compare and subtract per cycle, one bit of
// the bank number per step. A zero divisor leaves the bank number unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module clbm_mod_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire clbm_pkg::mod_ctrl_t ctrl_i,
  output      clbm_pkg::mod_sts_t  sts_o
);

  localparam int unsigned CntW = $clog2(clbm_pkg::BANK_W);

  logic                         busy_q, busy_d;
  logic                         valid_q, valid_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [clbm_pkg::BANK_W-1:0]  dvd_q, dvd_d;
  logic [clbm_pkg::COUNT_W-1:0] dvs_q, dvs_d;
  logic [clbm_pkg::BANK_W-1:0]  rem_q, rem_d;
  logic [clbm_pkg::BANK_W:0]    shifted;
  logic [clbm_pkg::COUNT_W-1:0] diff;

  always_comb begin
    busy_d  = busy_q;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    shifted = {rem_q, dvd_q[cnt_q]};
    diff    = clbm_pkg::COUNT_W'(shifted) - dvs_q;
    if (ctrl_i.start) begin
      busy_d  = 1'b1;
      valid_d = 1'b0;
      cnt_d   = CntW'(clbm_pkg::BANK_W - 1);
      dvd_d   = ctrl_i.dividend;
      dvs_d   = ctrl_i.divisor;
      rem_d   = '0;
    end else if (busy_q) begin
      if (clbm_pkg::COUNT_W'(shifted) >= dvs_q) begin
        rem_d = diff[clbm_pkg::BANK_W-1:0];
      end else begin
        rem_d = shifted[clbm_pkg::BANK_W-1:0];
      end
      if (cnt_q == '0) begin
        busy_d  = 1'b0;
        valid_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign sts_o.busy      = busy_q;
  assign sts_o.valid     = valid_q;
  assign sts_o.remainder = rem_q;

endmodule

`default_nettype wire

@@ rtl/chr_latch_bank_mapper_top.sv @@
// ----------------------------------------------------------------------------
// chr_latch_bank_mapper_top
// Cartridge bank mapper with pattern-fetch latches for CPU and PPU accesses.
//
// Channel   Dir  Handshake        Content
// s_*       in   tvalid/tready    bus access: tuser command, tdata address+data
// m_*       out  tvalid/tready    mapped access: tuser target, tdata address+data
// apb       in   psel/penable     configuration registers, 4 bytes apart
//
// A transaction is decoded at its acceptance edge, then takes four steps of the
// remainder unit and one load. A new transaction is accepted only when the
// sequencer is idle, which is from the cycle after the load.
// A result that is not taken stalls the sequencer before the load.
// Reset clears control state, the latches and the banks, and sets the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module chr_latch_bank_mapper_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,   // bus_address[15:0], write_data[23:16]
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // mapped_address[17:0], store_write[18],
                                      // store_data[26:19], zero
  output      logic [2:0]  m_tuser,   // target[2:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;

  logic [1:0]  state_q, state_d;
  logic [5:0]  prg_count_q;
  logic [17:0] prg_mask_q;
  logic [16:0] chr_mask_q;
  logic        chr_ram_q;
  logic [3:0]  prg_bank_q;
  logic [4:0]  pages_q [4];
  logic [1:0]  latch_q, latch_d;

  logic        item_acc, cfg_wr, finish;
  logic [1:0]  cmd;
  logic [15:0] baddr;
  logic [7:0]  wdata;
  logic [13:0] paddr14;
  logic        half;
  logic [15:0] rel;
  logic [4:0]  fix_bank;
  logic [4:0]  page;

  logic [2:0]  dec_tgt;
  logic [17:0] dec_addr;
  logic        dec_wr;
  logic [7:0]  dec_data;
  logic        dec_sw;

  logic [2:0]  held_tgt_q;
  logic [17:0] held_addr_q;
  logic        held_wr_q;
  logic [7:0]  held_data_q;
  logic        held_sw_q;
  logic [12:0] held_low_q;
  logic [17:0] fin_addr;

  logic        out_valid_q;
  logic [2:0]  out_tgt_q;
  logic [17:0] out_addr_q;
  logic        out_wr_q;
  logic [7:0]  out_data_q;

  clbm_pkg::mod_ctrl_t mod_ctrl;
  clbm_pkg::mod_sts_t  mod_sts;

  assign s_tready = (state_q == ST_IDLE);
  assign item_acc = s_tvalid && s_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign cmd     = s_tuser;
  assign baddr   = s_tdata[15:0];
  assign wdata   = s_tdata[23:16];
  assign paddr14 = baddr[13:0];
  assign half    = paddr14[12];
  assign rel     = baddr - clbm_pkg::ADDR_PRG_FIX;
  assign fix_bank = 5'(rel[14:13]) + prg_count_q[4:0] - 5'd3;

  always_comb begin
    latch_d = latch_q;
    if (cmd == clbm_pkg::CMD_PPU_RD && !paddr14[13]) begin
      if (paddr14 == clbm_pkg::TRIG_FD_LO || paddr14 == clbm_pkg::TRIG_FD_HI) begin
        latch_d[half] = 1'b0;
      end else if (paddr14 == clbm_pkg::TRIG_FE_LO || paddr14 == clbm_pkg::TRIG_FE_HI) begin
        latch_d[half] = 1'b1;
      end
    end
  end

  assign page = pages_q[{half, latch_d[half]}];

  always_comb begin
    dec_tgt  = clbm_pkg::TGT_NONE;
    dec_addr = '0;
    dec_wr   = 1'b0;
    dec_data = '0;
    dec_sw   = 1'b0;
    unique case (cmd)
      clbm_pkg::CMD_CPU_RD: begin
        if (baddr < clbm_pkg::ADDR_PRG_RAM) begin
          dec_tgt = clbm_pkg::TGT_NONE;
        end else if (baddr < clbm_pkg::ADDR_PRG_SW) begin
          dec_tgt  = clbm_pkg::TGT_PRG_RAM;
          dec_addr = 18'(baddr[12:0]);
        end else if (baddr < clbm_pkg::ADDR_PRG_FIX) begin
          dec_tgt = clbm_pkg::TGT_PRG_ROM;
          dec_sw  = 1'b1;
        end else begin
          dec_tgt  = clbm_pkg::TGT_PRG_ROM;
          dec_addr = {fix_bank, rel[12:0]} & prg_mask_q;
        end
      end
      clbm_pkg::CMD_CPU_WR: begin
        if (baddr >= clbm_pkg::ADDR_PRG_RAM && baddr < clbm_pkg::ADDR_PRG_SW) begin
          dec_tgt  = clbm_pkg::TGT_PRG_RAM;
          dec_addr = 18'(baddr[12:0]);
          dec_wr   = 1'b1;
          dec_data = wdata;
        end
      end
      clbm_pkg::CMD_PPU_RD: begin
        if (!paddr14[13]) begin
          if (chr_ram_q) begin
            dec_tgt  = clbm_pkg::TGT_CHR_RAM;
            dec_addr = 18'(paddr14[12:0]);
          end else begin
            dec_tgt  = clbm_pkg::TGT_CHR_ROM;
            dec_addr = 18'({page, paddr14[11:0]} & chr_mask_q);
          end
        end
      end
      clbm_pkg::CMD_PPU_WR: begin
        if (!paddr14[13] && chr_ram_q) begin
          dec_tgt  = clbm_pkg::TGT_CHR_RAM;
          dec_addr = 18'(paddr14[12:0]);
          dec_wr   = 1'b1;
          dec_data = wdata;
        end
      end
      default: dec_tgt = clbm_pkg::TGT_NONE;
    endcase
  end

  assign mod_ctrl.start    = item_acc;
  assign mod_ctrl.dividend = prg_bank_q;
  assign mod_ctrl.divisor  = prg_count_q;

  clbm_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mod_ctrl),
    .sts_o  (mod_sts)
  );

  assign finish   = (state_q == ST_CALC) && mod_sts.valid && (!out_valid_q || m_tready);
  assign fin_addr = held_sw_q ? ({1'b0, mod_sts.remainder, held_low_q} & prg_mask_q)
                              : held_addr_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (item_acc) state_d = ST_CALC;
      ST_CALC: if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prg_count_q <= 6'd16;
      prg_mask_q  <= 18'h1FFFF;
      chr_mask_q  <= 17'h1FFFF;
      chr_ram_q   <= 1'b0;
      prg_bank_q  <= '0;
      pages_q     <= '{default: '0};
      latch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          clbm_pkg::REG_PRG_COUNT: prg_count_q <= pwdata[5:0];
          clbm_pkg::REG_PRG_MASK:  prg_mask_q  <= pwdata[17:0];
          clbm_pkg::REG_CHR_MASK:  chr_mask_q  <= pwdata[16:0];
          clbm_pkg::REG_CHR_RAM:   chr_ram_q   <= pwdata[0];
          default: ;
        endcase
      end
      if (item_acc) begin
        latch_q <= latch_d;
        if (cmd == clbm_pkg::CMD_CPU_WR) begin
          unique case (baddr[15:12])
            clbm_pkg::WR_PRG_BANK: prg_bank_q <= wdata[3:0];
            clbm_pkg::WR_PAGE_LFD: pages_q[0] <= wdata[4:0];
            clbm_pkg::WR_PAGE_LFE: pages_q[1] <= wdata[4:0];
            clbm_pkg::WR_PAGE_RFD: pages_q[2] <= wdata[4:0];
            clbm_pkg::WR_PAGE_RFE: pages_q[3] <= wdata[4:0];
            default: ;
          endcase
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      held_tgt_q  <= dec_tgt;
      held_addr_q <= dec_addr;
      held_wr_q   <= dec_wr;
      held_data_q <= dec_data;
      held_sw_q   <= dec_sw;
      held_low_q  <= baddr[12:0];
    end
    if (finish) begin
      out_tgt_q  <= held_tgt_q;
      out_addr_q <= fin_addr;
      out_wr_q   <= held_wr_q;
      out_data_q <= held_data_q;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      clbm_pkg::REG_PRG_COUNT: prdata = 32'(prg_count_q);
      clbm_pkg::REG_PRG_MASK:  prdata = 32'(prg_mask_q);
      clbm_pkg::REG_CHR_MASK:  prdata = 32'(chr_mask_q);
      clbm_pkg::REG_CHR_RAM:   prdata = 32'(chr_ram_q);
      default:                 prdata = '0;
    endcase
  end

  assign m_tvalid = out_valid_q;
  assign m_tuser  = out_tgt_q;
  assign m_tdata  = {5'd0, out_data_q, out_wr_q, out_addr_q};

  `ASSERT_NEXT(a_accept_starts_unit, s_tvalid && s_tready, mod_sts.busy && !s_tready)
  `ASSERT_SAME(a_none_zero_addr, m_tvalid && m_tuser == clbm_pkg::TGT_NONE, m_tdata[17:0] == '0)
  `ASSERT_SAME(a_no_write_zero_data, m_tvalid && !m_tdata[18], m_tdata[26:19] == '0)
  `ASSERT_NEXT(a_stalled_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

`default_nettype wire
